[sv/assert_macros.svh]
// Shared assertion macros, clocked on clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked outside reset.
`define DRRF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked during reset too.
`define DRRF_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/drrf_pkg.sv]
`default_nettype none

package drrf_pkg;

  localparam int IN_W  = 112;
  localparam int OUT_W = 144;

  localparam int OUT_TIR_BIT   = 136;
  localparam int OUT_TV_LSB    = 76;
  localparam int OUT_TV_MSB    = 135;
  localparam logic [15:0] REFL_ONE = 16'h8000;

  // stage map
  localparam int ST_LOAD   = 0;
  localparam int ST_SUM    = 1;
  localparam int ST_DOT    = 2;
  localparam int ST_REFL   = 3;
  localparam int ST_SIN    = 4;
  localparam int ST_QINIT  = 5;
  localparam int ST_QDIV   = 6;
  localparam int QDIV_NST  = 8;
  localparam int QDIV_BITS = 4;
  localparam int QDIV_TOP  = 28;
  localparam int ST_SEL    = 14;
  localparam int ST_SQRT   = 15;
  localparam int SQRT_NST  = 8;
  localparam int SQRT_BITS = 4;
  localparam int SQRT_TOP  = 28;
  localparam int ST_PROD   = 23;
  localparam int ST_PREP   = 24;
  localparam int ST_FDIV   = 25;
  localparam int FDIV_NST  = 5;
  localparam int FDIV_BITS = 4;
  localparam int FDIV_TOP  = 18;
  localparam int ST_RMUL   = 25;
  localparam int ST_RNUM   = 26;
  localparam int ST_RDIV   = 27;
  localparam int RDIV_NST  = 4;
  localparam int RDIV_BITS = 5;
  localparam int RDIV_TOP  = 19;
  localparam int ST_SQ     = 30;
  localparam int ST_OUT    = 31;
  localparam int NSTAGE    = 32;

  localparam logic [29:0] ST2_ONE = 30'h1000_0000;
  localparam logic [29:0] ST2_BIG = 30'h2000_0000;
  localparam logic [28:0] CI_ONE  = 29'h1000_0000;

  typedef struct packed {
    logic [2:0][15:0] iv;
    logic [2:0][15:0] nv;
    logic [15:0]      m;
    logic [31:0]      mm;
    logic [2:0][31:0] pr;
    logic [33:0]      d;
    logic [2:0][49:0] dn;
    logic             c_pos;
    logic             c_zero;
    logic [28:0]      ci;
    logic [57:0]      ci2;
    logic [2:0][19:0] rfl;
    logic [28:0]      s2;
    logic [29:0]      ins;
    logic             ovf_o;
    logic [31:0]      orem;
    logic [28:0]      oq;
    logic             tir;
    logic             ref_ok;
    logic [28:0]      y;
    logic [31:0]      srem;
    logic [29:0]      root;
    logic [44:0]      a_s;
    logic [44:0]      b_s;
    logic [44:0]      a_p;
    logic [44:0]      b_p;
    logic [44:0]      mci;
    logic [44:0]      mct;
    logic [2:0][32:0] av;
    logic [44:0]      fden_s;
    logic [44:0]      fden_p;
    logic [44:0]      frem_s;
    logic [44:0]      frem_p;
    logic             fbit_s;
    logic             fbit_p;
    logic [18:0]      rs;
    logic [18:0]      rp;
    logic [46:0]      gg;
    logic [15:0]      rden;
    logic [2:0][62:0] pg;
    logic [2:0][35:0] yq;
    logic [2:0]       rneg;
    logic [2:0]       rovf;
    logic [2:0][15:0] rrem;
    logic [2:0][19:0] rq;
    logic [37:0]      sq_s;
    logic [37:0]      sq_p;
    logic [15:0]      refl;
    logic [2:0][19:0] tv;
  } pipe_t;

  function automatic logic [19:0] sat20(input logic neg, input logic [35:0] mag);
    logic [19:0] r;
    if (!neg) begin
      r = (mag > 36'd524287) ? 20'h7FFFF : mag[19:0];
    end else begin
      r = (mag > 36'd524288) ? 20'h80000 : 20'(-mag[19:0]);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[sv/drrf_stage.sv]
`default_nettype none

module drrf_stage import drrf_pkg::*; #(
  parameter int STAGE = 0
) (
  input  pipe_t p_i,
  output pipe_t p_o
);

  always_comb begin
    logic [15:0]        mfix;
    logic signed [33:0] sd;
    logic signed [51:0] rn;
    logic [51:0]        rmag;
    logic [51:0]        rsum;
    logic [57:0]        t58;
    logic [61:0]        prod;
    logic [32:0]        qt;
    logic [57:0]        xv;
    logic [31:0]        st;
    logic [31:0]        trial;
    logic [1:0]         pair;
    logic [28:0]        ct;
    logic [15:0]        ei;
    logic [15:0]        et;
    logic [44:0]        ds;
    logic [44:0]        dp;
    logic [45:0]        ft;
    logic [29:0]        st2o;
    logic [29:0]        st2f;
    logic [29:0]        st2r;
    logic signed [63:0] num;
    logic [63:0]        mag;
    logic [63:0]        ysum;
    logic [16:0]        rt;
    logic [38:0]        fsum;
    logic               inner;
    int                 base;
    int                 ib;

    p_o   = p_i;
    mfix  = '0;
    sd    = '0;
    rn    = '0;
    rmag  = '0;
    rsum  = '0;
    t58   = '0;
    prod  = '0;
    qt    = '0;
    xv    = '0;
    st    = '0;
    trial = '0;
    pair  = '0;
    ct    = p_i.root[28:0];
    ei    = '0;
    et    = '0;
    ds    = '0;
    dp    = '0;
    ft    = '0;
    st2o  = '0;
    st2f  = '0;
    st2r  = '0;
    num   = '0;
    mag   = '0;
    ysum  = '0;
    rt    = '0;
    fsum  = '0;
    inner = p_i.c_pos | p_i.c_zero;
    base  = 0;
    ib    = 0;

    if (STAGE == ST_LOAD) begin
      mfix = (p_i.m == '0) ? 16'd1 : p_i.m;
      p_o.m  = mfix;
      p_o.mm = {16'd0, mfix} * {16'd0, mfix};
      for (int j = 0; j < 3; j++) begin
        p_o.pr[j] = 32'($signed(p_i.iv[j])) * 32'($signed(p_i.nv[j]));
      end
    end

    if (STAGE == ST_SUM) begin
      p_o.d = 34'($signed(p_i.pr[0])) + 34'($signed(p_i.pr[1])) + 34'($signed(p_i.pr[2]));
    end

    if (STAGE == ST_DOT) begin
      sd = $signed(p_i.d);
      for (int j = 0; j < 3; j++) begin
        p_o.dn[j] = 50'(sd) * 50'($signed(p_i.nv[j]));
      end
      if (sd > 34'sd268435456 || sd < -34'sd268435456) begin
        p_o.ci = CI_ONE;
      end else if (sd < 0) begin
        p_o.ci = 29'(-sd);
      end else begin
        p_o.ci = 29'(sd);
      end
      p_o.c_pos  = sd > 0;
      p_o.c_zero = p_i.d == '0;
    end

    if (STAGE == ST_REFL) begin
      p_o.ci2 = {29'd0, p_i.ci} * {29'd0, p_i.ci};
      for (int j = 0; j < 3; j++) begin
        rn   = (52'($signed(p_i.iv[j])) <<< 28) - (52'($signed(p_i.dn[j])) <<< 1);
        rmag = rn[51] ? 52'(-rn) : 52'(rn);
        rsum = (rmag + 52'd134217728) >> 28;
        p_o.rfl[j] = sat20(rn[51], rsum[35:0]);
      end
    end

    if (STAGE == ST_SIN) begin
      t58 = (58'd1 << 56) - p_i.ci2;
      p_o.s2 = t58[56:28];
    end

    if (STAGE == ST_QINIT) begin
      prod = {33'd0, p_i.s2} * {30'd0, p_i.mm};
      p_o.ins   = (|prod[61:57]) ? ST2_BIG : {1'b0, prod[56:28]};
      p_o.ovf_o = {4'd0, p_i.s2} >= {p_i.mm, 1'b0};
      p_o.orem  = {4'd0, p_i.s2[28:1]};
      p_o.oq    = '0;
    end

    if (STAGE >= ST_QDIV && STAGE < ST_QDIV + QDIV_NST) begin
      base = (STAGE - ST_QDIV) * QDIV_BITS;
      for (int n = 0; n < QDIV_BITS; n++) begin
        ib = QDIV_TOP - base - n;
        if (ib >= 0) begin
          qt = {p_o.orem, (ib == QDIV_TOP) ? p_i.s2[0] : 1'b0};
          if (qt >= {1'b0, p_i.mm}) begin
            qt = qt - {1'b0, p_i.mm};
            p_o.oq = {p_o.oq[27:0], 1'b1};
          end else begin
            p_o.oq = {p_o.oq[27:0], 1'b0};
          end
          p_o.orem = qt[31:0];
        end
      end
    end

    if (STAGE == ST_SEL) begin
      st2o = p_i.ovf_o ? ST2_BIG : {1'b0, p_i.oq};
      st2f = p_i.c_pos ? p_i.ins : st2o;
      st2r = inner ? p_i.ins : st2o;
      p_o.tir    = st2f >= ST2_ONE;
      p_o.ref_ok = (st2f < ST2_ONE) && (st2r <= ST2_ONE);
      p_o.y      = (st2r <= ST2_ONE) ? 29'(ST2_ONE - st2r) : '0;
      p_o.srem   = '0;
      p_o.root   = '0;
    end

    if (STAGE >= ST_SQRT && STAGE < ST_SQRT + SQRT_NST) begin
      base = (STAGE - ST_SQRT) * SQRT_BITS;
      xv = {1'b0, p_i.y, 28'd0};
      for (int n = 0; n < SQRT_BITS; n++) begin
        ib = SQRT_TOP - base - n;
        if (ib >= 0) begin
          pair  = 2'(xv >> (2 * ib));
          st    = {p_o.srem[29:0], pair};
          trial = {p_o.root, 2'b01};
          if (st >= trial) begin
            p_o.srem = st - trial;
            p_o.root = {p_o.root[28:0], 1'b1};
          end else begin
            p_o.srem = st;
            p_o.root = {p_o.root[28:0], 1'b0};
          end
        end
      end
    end

    if (STAGE == ST_PROD) begin
      ei = p_i.c_pos ? p_i.m : 16'h4000;
      et = p_i.c_pos ? 16'h4000 : p_i.m;
      p_o.a_s = {29'd0, et} * {16'd0, p_i.ci};
      p_o.b_s = {29'd0, ei} * {16'd0, ct};
      p_o.a_p = {29'd0, ei} * {16'd0, p_i.ci};
      p_o.b_p = {29'd0, et} * {16'd0, ct};
      p_o.mci = {29'd0, p_i.m} * {16'd0, p_i.ci};
      p_o.mct = {29'd0, p_i.m} * {16'd0, ct};
      for (int j = 0; j < 3; j++) begin
        if (inner) begin
          p_o.av[j] = 33'($signed({1'b0, p_i.m})) * 33'($signed(p_i.iv[j]));
        end else begin
          p_o.av[j] = 33'($signed(p_i.iv[j])) <<< 14;
        end
      end
    end

    if (STAGE == ST_PREP) begin
      ds = (p_i.a_s > p_i.b_s) ? p_i.a_s - p_i.b_s : p_i.b_s - p_i.a_s;
      dp = (p_i.a_p > p_i.b_p) ? p_i.a_p - p_i.b_p : p_i.b_p - p_i.a_p;
      p_o.fden_s = p_i.a_s + p_i.b_s;
      p_o.fden_p = p_i.a_p + p_i.b_p;
      p_o.frem_s = ds >> 1;
      p_o.frem_p = dp >> 1;
      p_o.fbit_s = ds[0];
      p_o.fbit_p = dp[0];
      p_o.rs     = '0;
      p_o.rp     = '0;
      if (inner) begin
        p_o.gg = 47'(p_i.mci) - 47'({ct, 14'd0});
      end else begin
        p_o.gg = 47'(p_i.mct) - 47'({p_i.ci, 14'd0});
      end
      p_o.rden = inner ? 16'h4000 : p_i.m;
    end

    if (STAGE == ST_RMUL) begin
      for (int j = 0; j < 3; j++) begin
        p_o.pg[j] = 63'($signed(p_i.gg)) * 63'($signed(p_i.nv[j]));
      end
    end

    if (STAGE >= ST_FDIV && STAGE < ST_FDIV + FDIV_NST) begin
      base = (STAGE - ST_FDIV) * FDIV_BITS;
      for (int n = 0; n < FDIV_BITS; n++) begin
        ib = FDIV_TOP - base - n;
        if (ib >= 0) begin
          ft = {p_o.frem_s, (ib == FDIV_TOP) ? p_i.fbit_s : 1'b0};
          if (ft >= {1'b0, p_i.fden_s}) begin
            ft = ft - {1'b0, p_i.fden_s};
            p_o.rs = {p_o.rs[17:0], 1'b1};
          end else begin
            p_o.rs = {p_o.rs[17:0], 1'b0};
          end
          p_o.frem_s = ft[44:0];
          ft = {p_o.frem_p, (ib == FDIV_TOP) ? p_i.fbit_p : 1'b0};
          if (ft >= {1'b0, p_i.fden_p}) begin
            ft = ft - {1'b0, p_i.fden_p};
            p_o.rp = {p_o.rp[17:0], 1'b1};
          end else begin
            p_o.rp = {p_o.rp[17:0], 1'b0};
          end
          p_o.frem_p = ft[44:0];
        end
      end
    end

    if (STAGE == ST_RNUM) begin
      for (int j = 0; j < 3; j++) begin
        num  = (64'($signed(p_i.av[j])) <<< 28) - 64'($signed(p_i.pg[j]));
        mag  = num[63] ? 64'(-num) : 64'(num);
        ysum = mag + ({48'd0, p_i.rden} << 27);
        p_o.yq[j]   = ysum[63:28];
        p_o.rneg[j] = num[63];
        p_o.rovf[j] = ysum[63:28] >= {p_i.rden, 20'd0};
        p_o.rrem[j] = ysum[63:48];
        p_o.rq[j]   = '0;
      end
    end

    if (STAGE >= ST_RDIV && STAGE < ST_RDIV + RDIV_NST) begin
      base = (STAGE - ST_RDIV) * RDIV_BITS;
      for (int j = 0; j < 3; j++) begin
        for (int n = 0; n < RDIV_BITS; n++) begin
          ib = RDIV_TOP - base - n;
          if (ib >= 0) begin
            rt = {p_o.rrem[j], 1'(p_i.yq[j] >> ib)};
            if (rt >= {1'b0, p_i.rden}) begin
              rt = rt - {1'b0, p_i.rden};
              p_o.rq[j] = {p_o.rq[j][18:0], 1'b1};
            end else begin
              p_o.rq[j] = {p_o.rq[j][18:0], 1'b0};
            end
            p_o.rrem[j] = rt[15:0];
          end
        end
      end
    end

    if (STAGE == ST_SQ) begin
      p_o.sq_s = {19'd0, p_i.rs} * {19'd0, p_i.rs};
      p_o.sq_p = {19'd0, p_i.rp} * {19'd0, p_i.rp};
    end

    if (STAGE == ST_OUT) begin
      fsum = {1'b0, p_i.sq_s} + {1'b0, p_i.sq_p} + 39'd2097152;
      // total internal reflection or grazing hit: reflectance is one (at grazing both ratios are exactly one)
      p_o.refl = (p_i.tir || p_i.c_zero) ? REFL_ONE : fsum[37:22];
      for (int j = 0; j < 3; j++) begin
        if (!p_i.ref_ok) begin
          p_o.tv[j] = '0;
        end else if (p_i.rovf[j]) begin
          p_o.tv[j] = sat20(p_i.rneg[j], '1);
        end else begin
          p_o.tv[j] = sat20(p_i.rneg[j], {16'd0, p_i.rq[j]});
        end
      end
    end
  end

endmodule

`default_nettype wire

[sv/dielectric_reflect_refract_fresnel_unit.sv]
// Dielectric hit shader: mirror reflection, Snell refraction and unpolarized
// Fresnel reflectance for one ray hit per beat. The datapath is a 32-stage
// pipeline; a new hit can be taken every cycle while the result side is ready
// or some stage is empty. The sin^2 divide, the square root and the
// reflectance and refraction divides are digit-recurrence units unrolled
// across stages (four or five quotient or root bits per stage), and their
// chain sets the depth. A stall on the result side holds the pipeline; empty
// stages keep filling, so input is still taken while a result waits.
`default_nettype none

module dielectric_reflect_refract_fresnel_unit import drrf_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output      logic             in_tready,
  // incident_x, incident_y, incident_z, normal_x, normal_y, normal_z,
  // material_ior
  input  wire logic [IN_W-1:0]  in_tdata,
  output      logic             out_tvalid,
  input  wire logic             out_tready,
  // reflectance, reflect_x, reflect_y, reflect_z, refract_x, refract_y,
  // refract_z, total_internal, zero fill
  output      logic [OUT_W-1:0] out_tdata
);

  pipe_t             in_p;
  pipe_t             stage_in [NSTAGE];
  pipe_t             st_nxt   [NSTAGE];
  pipe_t             st_r     [NSTAGE];
  logic [NSTAGE-1:0] v_r;
  logic [NSTAGE-1:0] v_nxt;
  logic [NSTAGE-1:0] en;
  pipe_t             last;

  always_comb begin
    in_p      = '0;
    in_p.iv[0] = in_tdata[15:0];
    in_p.iv[1] = in_tdata[31:16];
    in_p.iv[2] = in_tdata[47:32];
    in_p.nv[0] = in_tdata[63:48];
    in_p.nv[1] = in_tdata[79:64];
    in_p.nv[2] = in_tdata[95:80];
    in_p.m     = in_tdata[111:96];
  end

  assign stage_in[0] = in_p;

  for (genvar k = 0; k < NSTAGE; k++) begin : g_st
    if (k > 0) begin : g_link
      assign stage_in[k] = st_r[k-1];
    end

    // a stage moves when the output is ready or some stage at or after it is empty
    assign en[k] = out_tready || !(&v_r[NSTAGE-1:k]);

    drrf_stage #(.STAGE(k)) u_stage (
      .p_i (stage_in[k]),
      .p_o (st_nxt[k])
    );

    always_ff @(posedge clk) begin
      if (en[k]) begin
        st_r[k] <= st_nxt[k];
      end
    end
  end

  always_comb begin
    v_nxt = v_r;
    for (int k = 0; k < NSTAGE; k++) begin
      if (en[k]) begin
        v_nxt[k] = (k == 0) ? in_tvalid : v_r[(k == 0) ? 0 : k - 1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_tready  = en[0];
  assign last       = st_r[NSTAGE-1];
  assign out_tvalid = v_r[NSTAGE-1];
  assign out_tdata  = {7'd0, last.tir, last.tv[2], last.tv[1], last.tv[0],
                       last.rfl[2], last.rfl[1], last.rfl[0], last.refl};

endmodule

`default_nettype wire

[sv/drrf_chk.sv]
`default_nettype none
`include "assert_macros.svh"

module drrf_chk import drrf_pkg::*; (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             out_tvalid,
  input wire logic             out_tready,
  input wire logic [OUT_W-1:0] out_tdata
);

  `DRRF_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid, "result beat dropped")
  `DRRF_ASSERT(a_out_stable, out_tvalid && !out_tready |=> $stable(out_tdata), "stalled beat changed")
  `DRRF_ASSERT(a_tir_out, out_tvalid && out_tdata[OUT_TIR_BIT] |-> out_tdata[15:0] == REFL_ONE && out_tdata[OUT_TV_MSB:OUT_TV_LSB] == '0, "bad total internal reflection beat")
  `DRRF_ASSERT(a_refl_max, out_tvalid |-> out_tdata[15:0] <= REFL_ONE, "reflectance above one")
  `DRRF_ASSERT_NR(a_rst_empty, !rst_n |=> !out_tvalid, "result valid after reset")

endmodule

bind dielectric_reflect_refract_fresnel_unit drrf_chk u_drrf_chk (.*);

`default_nettype wire

[tb/fresnel_checker.sv]
`timescale 1ns / 100ps
`default_nettype none

module fresnel_checker import drrf_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  input  wire logic             in_tready,
  input  wire logic [IN_W-1:0]  in_tdata,
  input  wire logic             out_tvalid,
  input  wire logic             out_tready,
  input  wire logic [OUT_W-1:0] out_tdata,
  output int                    errors,
  output int                    pending,
  output int                    n_checked,
  output int                    n_tir
);

  localparam longint Q14 = 64'sd16384;
  localparam longint Q28 = 64'sd268435456;
  localparam longint Q42 = 64'sd4398046511104;

  logic [OUT_W-1:0] shade_q[$];

  function automatic longint round_div(longint num, longint unsigned den);
    longint unsigned mag;
    mag = (num < 0) ? longint'(-num) : longint'(num);
    mag = (mag + den / 2) / den;
    return (num < 0) ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic logic [19:0] clip20(longint v);
    if (v > 524287) v = 524287;
    if (v < -524288) v = -524288;
    return v[19:0];
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint unsigned snell_sin2(longint unsigned s2, longint unsigned m,
                                                 bit inner);
    return inner ? (s2 * m * m) >> 28 : (s2 << 28) / (m * m);
  endfunction

  function automatic longint unsigned amp_ratio(longint unsigned a, longint unsigned b);
    longint unsigned dd;
    dd = (a > b) ? a - b : b - a;
    return (dd << 18) / (a + b);
  endfunction

  function automatic logic [OUT_W-1:0] shade_hit(logic [IN_W-1:0] h);
    longint iv[3], nv[3], tv[3];
    longint d, c, g, cts, mi;
    longint unsigned m, ci, s2, st2f, st2r, refl, ct, ei, et, rs, rp;
    bit tir;
    logic [OUT_W-1:0] r;
    r = '0;
    d = 0;
    for (int j = 0; j < 3; j++) begin
      iv[j] = longint'($signed(h[16*j +: 16]));
      nv[j] = longint'($signed(h[48 + 16*j +: 16]));
      d = d + iv[j] * nv[j];
      tv[j] = 0;
    end
    m = h[111:96];
    if (m == 0) m = 1;
    for (int j = 0; j < 3; j++)
      r[16 + 20*j +: 20] = clip20(round_div(iv[j] * Q28 - 2 * d * nv[j], Q28));
    c = (d > Q28) ? Q28 : ((d < -Q28) ? -Q28 : d);
    ci = (c < 0) ? longint'(-c) : longint'(c);
    s2 = ((64'd1 << 56) - ci * ci) >> 28;
    st2f = snell_sin2(s2, m, c > 0);
    tir = st2f >= Q28;
    if (tir) begin
      refl = 32768;
    end else begin
      ct = int_sqrt((Q28 - st2f) << 28);
      ei = (c > 0) ? m : Q14;
      et = (c > 0) ? Q14 : m;
      rs = amp_ratio(et * ci, ei * ct);
      rp = amp_ratio(ei * ci, et * ct);
      refl = (rs * rs + rp * rp + (64'd1 << 21)) >> 22;
    end
    st2r = snell_sin2(s2, m, c >= 0);
    if (!tir && st2r <= Q28) begin
      cts = longint'(int_sqrt((Q28 - st2r) << 28));
      mi = longint'(m);
      if (c >= 0) begin
        g = mi * longint'(ci) - cts * Q14;
        for (int j = 0; j < 3; j++)
          tv[j] = round_div(mi * iv[j] * Q28 - g * nv[j], Q42);
      end else begin
        g = longint'(ci) * Q14 - mi * cts;
        for (int j = 0; j < 3; j++)
          tv[j] = round_div(iv[j] * Q42 + g * nv[j], m << 28);
      end
    end
    r[15:0] = refl[15:0];
    for (int j = 0; j < 3; j++) r[76 + 20*j +: 20] = clip20(tv[j]);
    r[OUT_TIR_BIT] = tir;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t ns: beat %0d %s mismatch: got %h want %h", $time, n_checked, what, got,
             want);
    errors++;
  endtask

  always @(posedge clk) begin
    logic [OUT_W-1:0] want;
    if (!rst_n) begin
      shade_q.delete();
    end else begin
      if (in_tvalid && in_tready) shade_q.push_back(shade_hit(in_tdata));
      if (out_tvalid && out_tready) begin
        if (shade_q.size() == 0) begin
          report_mismatch("unexpected", out_tdata[63:0], '0);
        end else begin
          want = shade_q.pop_front();
          if (out_tdata[15:0] !== want[15:0])
            report_mismatch("reflectance", out_tdata[15:0], want[15:0]);
          for (int j = 0; j < 3; j++) begin
            if (out_tdata[16 + 20*j +: 20] !== want[16 + 20*j +: 20])
              report_mismatch($sformatf("reflect[%0d]", j), out_tdata[16 + 20*j +: 20],
                              want[16 + 20*j +: 20]);
            if (out_tdata[76 + 20*j +: 20] !== want[76 + 20*j +: 20])
              report_mismatch($sformatf("refract[%0d]", j), out_tdata[76 + 20*j +: 20],
                              want[76 + 20*j +: 20]);
          end
          if (out_tdata[OUT_TIR_BIT] !== want[OUT_TIR_BIT])
            report_mismatch("total_internal", out_tdata[OUT_TIR_BIT], want[OUT_TIR_BIT]);
          if (want[OUT_TIR_BIT]) n_tir++;
        end
        n_checked++;
      end
    end
    pending <= shade_q.size();
  end

  initial begin
    errors = 0;
    pending = 0;
    n_checked = 0;
    n_tir = 0;
  end

endmodule

`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 100ps
`default_nettype none

module tb;
  import drrf_pkg::*;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [IN_W-1:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [OUT_W-1:0] out_tdata;
  int errors, pending, n_checked, n_tir;
  bit hold_req;
  int n_sent;

  dielectric_reflect_refract_fresnel_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  fresnel_checker u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .errors     (errors),
    .pending    (pending),
    .n_checked  (n_checked),
    .n_tir      (n_tir)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // receiver: random stalls, quiet stretches, one long hold-off on request
  initial begin
    int gap, quiet;
    bit held;
    out_tready <= 1'b0;
    gap = 0;
    quiet = 0;
    held = 0;
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        held = 1;
        out_tready <= 1'b0;
        repeat (200) @(posedge clk);
        out_tready <= 1'b1;
      end else if (quiet > 0) begin
        quiet--;
        out_tready <= 1'b1;
      end else if (gap > 0) begin
        gap--;
        out_tready <= 1'b0;
      end else begin
        if ($urandom_range(0, 99) < 3) quiet = $urandom_range(30, 80);
        else gap = gap_len();
        out_tready <= (gap == 0);
      end
    end
  end

  task automatic send_hit(logic [15:0] ix, logic [15:0] iy, logic [15:0] iz,
                          logic [15:0] nx, logic [15:0] ny, logic [15:0] nz,
                          logic [15:0] ior, bit no_gap);
    int gap;
    gap = no_gap ? 0 : gap_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {ior, nz, ny, nx, iz, iy, ix};
    do @(posedge clk); while (!in_tready);
    n_sent++;
  endtask

  function automatic logic [15:0] to_q14(real v);
    int k;
    k = int'(v * 16384.0) + $urandom_range(0, 4) - 2;
    if (k > 32767) k = 32767;
    if (k < -32768) k = -32768;
    return k[15:0];
  endfunction

  task automatic unit_vec(output logic [15:0] x, output logic [15:0] y,
                          output logic [15:0] z);
    real a, b, c, n;
    do begin
      a = $itor($urandom_range(0, 2000)) - 1000.0;
      b = $itor($urandom_range(0, 2000)) - 1000.0;
      c = $itor($urandom_range(0, 2000)) - 1000.0;
      n = $sqrt(a * a + b * b + c * c);
    end while (n < 10.0);
    x = to_q14(a / n);
    y = to_q14(b / n);
    z = to_q14(c / n);
  endtask

  initial begin
    logic [15:0] ix, iy, iz, nx, ny, nz, ior;
    int r;
    bit quiet;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    hold_req = 0;
    n_sent = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // head-on, grazing and oblique hits from both sides
    send_hit(16'h0000, 16'h0000, 16'hC000, 16'h0000, 16'h0000, 16'h4000, 16'h6000, 0);
    send_hit(16'h0000, 16'h0000, 16'h4000, 16'h0000, 16'h0000, 16'h4000, 16'h6000, 0);
    send_hit(16'h4000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h4000, 16'h6000, 0);
    send_hit(16'h2D41, 16'h0000, 16'hD2BF, 16'h0000, 16'h0000, 16'h4000, 16'h6000, 1);
    send_hit(16'h2D41, 16'h0000, 16'h2D41, 16'h0000, 16'h0000, 16'h4000, 16'h6000, 1);
    send_hit(16'h2D41, 16'h0000, 16'h2D41, 16'h0000, 16'h0000, 16'h4000, 16'h4000, 0);
    send_hit(16'h3B21, 16'h0000, 16'h187E, 16'h0000, 16'h0000, 16'h4000, 16'hFFFF, 0);
    // index range ends, zero index
    send_hit(16'h1000, 16'h2000, 16'hD000, 16'h0000, 16'h4000, 16'h0000, 16'hFFFF, 0);
    send_hit(16'h1000, 16'h2000, 16'hD000, 16'h0000, 16'h4000, 16'h0000, 16'h4000, 0);
    send_hit(16'h1000, 16'h2000, 16'hD000, 16'h0000, 16'h4000, 16'h0000, 16'h0000, 0);
    send_hit(16'h1000, 16'h2000, 16'h3000, 16'h0000, 16'h4000, 16'h0000, 16'h0000, 0);
    send_hit(16'h1000, 16'h2000, 16'h3000, 16'h0000, 16'h4000, 16'h0000, 16'h0001, 0);
    // non-unit vectors, saturation
    send_hit(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 0);
    send_hit(16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 0);
    send_hit(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'hFFFF, 0);
    send_hit(16'h7FFF, 16'h8000, 16'h0000, 16'h8000, 16'h7FFF, 16'h0000, 16'h4000, 1);
    send_hit(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h5000, 0);
    send_hit(16'h0001, 16'hFFFF, 16'h0001, 16'hFFFF, 16'h0001, 16'hFFFF, 16'h0000, 0);
    send_hit(16'h0000, 16'h0000, 16'h4000, 16'h0000, 16'h0000, 16'h8000, 16'h6000, 0);

    quiet = 0;
    for (int k = 0; k < 500; k++) begin
      if (k == 200) hold_req = 1;
      if (k % 60 == 0) quiet = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 25) begin
        {ix, iy} = $urandom;
        {iz, nx} = $urandom;
        {ny, nz} = $urandom;
        ior = 16'($urandom);
      end else begin
        unit_vec(ix, iy, iz);
        unit_vec(nx, ny, nz);
        if (r < 35) begin
          ix = nx;
          iy = ny;
          iz = -nz;
        end
        ior = 16'((r < 45) ? $urandom_range(0, 65535) : $urandom_range(16384, 65535));
      end
      send_hit(ix, iy, iz, nx, ny, nz, ior, quiet || (k >= 200 && k < 260));
    end
    in_tvalid <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (40) @(posedge clk);
    $display("Sent %0d ray hits, checked %0d results (%0d with total internal reflection),",
             n_sent, n_checked, n_tir);
    $display("across both sides of the surface, index extremes and saturating inputs.");
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Timeout with %0d results outstanding", pending);
    $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire
